// ===== design/pcxd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcxd_pkg
// Shared types, codes and helpers for the descrambling pcx rle decoder.
// ----------------------------------------------------------------------------
package pcxd_pkg;

   localparam int HEADER_BYTES  = 128;
   localparam int PALETTE_BYTES = 768;

   // header layout
   localparam logic [23:0] BPP_OFFSET    = 24'd3;
   localparam logic [23:0] PLANES_OFFSET = 24'd65;
   localparam logic [23:0] BOUNDS_FIRST  = 24'd4;
   localparam logic [23:0] BOUNDS_LAST   = 24'd11;
   localparam logic [23:0] HEADER_END    = 24'(HEADER_BYTES - 1);
   localparam logic [23:0] DATA_FIRST    = 24'(HEADER_BYTES);
   localparam logic [23:0] PALETTE_SIZE  = 24'(PALETTE_BYTES);

   localparam logic [7:0] REQUIRED_BPP    = 8'd8;
   localparam logic [7:0] REQUIRED_PLANES = 8'd1;
   localparam logic [7:0] RUN_MARK        = 8'hC0;

   typedef enum logic [1:0] {
      KIND_PIXEL   = 2'd0,
      KIND_PALETTE = 2'd1,
      KIND_STATUS  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_CHECKSUM    = 3'd1,
      STATUS_FORMAT      = 3'd2,
      STATUS_RUN_OVERRUN = 3'd3,
      STATUS_SHORT_IMAGE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_XOR_KEY       = 2'd0,
      CSR_CHECKSUM_SEED = 2'd1,
      CSR_FILE_SIZE     = 2'd2
   } csr_index_type;

   // hi - lo + 1 when positive, else zero
   function automatic logic [16:0] dim_calc(input logic [15:0] lo, input logic [15:0] hi);
      logic [17:0] diff;
      begin
         diff = {2'b00, hi} - {2'b00, lo} + 18'd1;
         dim_calc = (!diff[17] && (diff != 18'd0)) ? diff[16:0] : 17'd0;
      end
   endfunction

   function automatic status_type final_status(input logic [7:0] checksum,
                                               input status_type err,
                                               input logic short_file,
                                               input logic run_pending,
                                               input logic short_image);
      begin
         if (checksum != 8'd0)          final_status = STATUS_CHECKSUM;
         else if (err != STATUS_OK)     final_status = err;
         else if (short_file)           final_status = STATUS_FORMAT;
         else if (run_pending)          final_status = STATUS_RUN_OVERRUN;
         else if (short_image)          final_status = STATUS_SHORT_IMAGE;
         else                           final_status = STATUS_OK;
      end
   endfunction

endpackage

// ===== design/descrambling_pcx_rle_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// descrambling_pcx_rle_decoder
// Descrambles a pcx file byte by byte, checks it, reads the header and
// expands the rle pixel data and the trailing palette.
// ----------------------------------------------------------------------------
// A request carries one raw file byte. A small sequencer walks each byte
// through its steps: accept and descramble, size the image, decode, then give
// out the pixels, the palette byte or the closing status. The last header
// byte also passes through a pixel count multiply and a format check. While
// a byte is in the sequencer, req_stall holds off the next request.
// All results leave through one output register, so a stalled result
// channel also stalls the sequencer. Bytes past file_size are dropped with no
// result. After the final byte all file state clears for the next file.
module descrambling_pcx_rle_decoder #(
   parameter int MAX_PIXELS = 16777216
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_value,
   output logic [23:0] rsp_index,
   output logic [16:0] rsp_image_width,
   output logic [16:0] rsp_image_height,
   output logic [2:0]  rsp_status,
   output logic        rsp_file_done,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);

   localparam int PIX_W = $clog2(MAX_PIXELS + 1);
   localparam int SUM_W = ((PIX_W > 6) ? PIX_W : 6) + 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIM,
      S_MUL,
      S_FMT,
      S_DECODE,
      S_RUN,
      S_TAIL
   } state_type;

   state_type            state_ff;
   logic [7:0]           xor_key_ff;
   logic [7:0]           seed_ff;
   logic [23:0]          file_size_ff;
   logic [23:0]          byte_pos_ff;
   logic [7:0]           checksum_ff;
   logic [15:0]          bounds_ff [4];
   logic [7:0]           bpp_ff;
   logic [7:0]           planes_ff;
   logic [PIX_W-1:0]     target_ff;
   logic [PIX_W-1:0]     pix_cnt_ff;
   logic [6:0]           pending_ff;
   pcxd_pkg::status_type err_ff;

   // per request working registers
   logic [7:0]           data_ff;
   logic [23:0]          pos_ff;
   logic                 pal_emit_ff;
   logic [23:0]          pal_idx_ff;
   logic                 final_ff;
   logic                 emitted_ff;
   logic [16:0]          width_ff;
   logic [16:0]          height_ff;
   logic [33:0]          prod_ff;
   logic [5:0]           run_cnt_ff;

   // result register
   logic                 rsp_valid_ff;
   pcxd_pkg::kind_type   rsp_kind_ff;
   logic [7:0]           rsp_value_ff;
   logic [23:0]          rsp_index_ff;
   logic [16:0]          rsp_width_ff;
   logic [16:0]          rsp_height_ff;
   pcxd_pkg::status_type rsp_status_ff;
   logic                 rsp_file_done_ff;
   logic                 rsp_last_ff;

   logic                 accept;
   logic                 slot_free;
   logic [7:0]           plain_in;
   logic [7:0]           checksum_in;
   logic [23:0]          pal_start_in;
   logic [2:0]           bound_off;
   logic [PIX_W-1:0]     pix_cnt_in;
   logic [SUM_W-1:0]     run_end;
   logic                 run_overrun;
   logic                 short_file;
   pcxd_pkg::status_type status_after_pixel;
   pcxd_pkg::status_type status_at_tail;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign plain_in     = req_data_byte ^ xor_key_ff;
   assign checksum_in  = checksum_ff - req_data_byte;
   assign pal_start_in = (file_size_ff >= pcxd_pkg::PALETTE_SIZE)
                         ? (file_size_ff - pcxd_pkg::PALETTE_SIZE) : 24'd0;
   assign bound_off    = 3'(byte_pos_ff - pcxd_pkg::BOUNDS_FIRST);
   assign pix_cnt_in   = pix_cnt_ff + PIX_W'(1);
   assign run_end      = SUM_W'(pix_cnt_ff) + SUM_W'(data_ff[5:0]);
   assign run_overrun  = run_end > SUM_W'(target_ff);
   assign short_file   = file_size_ff < pcxd_pkg::DATA_FIRST;

   assign status_after_pixel = pcxd_pkg::final_status(checksum_ff, err_ff, short_file,
                                                      pending_ff[6], pix_cnt_in < target_ff);
   assign status_at_tail     = pcxd_pkg::final_status(checksum_ff, err_ff, short_file,
                                                      pending_ff[6], pix_cnt_ff < target_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         xor_key_ff   <= 8'd0;
         seed_ff      <= 8'd0;
         file_size_ff <= 24'd0;
         byte_pos_ff  <= 24'd0;
         checksum_ff  <= 8'd0;
         for (int i = 0; i < 4; i++) bounds_ff[i] <= 16'd0;
         bpp_ff       <= 8'd0;
         planes_ff    <= 8'd0;
         target_ff    <= '0;
         pix_cnt_ff   <= '0;
         pending_ff   <= 7'd0;
         err_ff       <= pcxd_pkg::STATUS_OK;
         emitted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (!rsp_stall) rsp_valid_ff <= 1'b0;

         if (csr_we) begin
            case (csr_index)
               pcxd_pkg::CSR_XOR_KEY: xor_key_ff <= csr_data[7:0];
               pcxd_pkg::CSR_CHECKSUM_SEED: begin
                  seed_ff <= csr_data[7:0];
                  if (byte_pos_ff == 24'd0) checksum_ff <= csr_data[7:0];
               end
               pcxd_pkg::CSR_FILE_SIZE: file_size_ff <= csr_data;
               default: ;
            endcase
         end

         case (state_ff)
            S_IDLE: begin
               if (accept && (byte_pos_ff < file_size_ff)) begin
                  data_ff     <= plain_in;
                  pos_ff      <= byte_pos_ff;
                  checksum_ff <= checksum_in;
                  byte_pos_ff <= byte_pos_ff + 24'd1;
                  pal_emit_ff <= byte_pos_ff >= pal_start_in;
                  pal_idx_ff  <= byte_pos_ff - pal_start_in;
                  final_ff    <= (byte_pos_ff + 24'd1) == file_size_ff;
                  emitted_ff  <= 1'b0;
                  if (byte_pos_ff == pcxd_pkg::BPP_OFFSET) bpp_ff <= plain_in;
                  else if (byte_pos_ff == pcxd_pkg::PLANES_OFFSET) planes_ff <= plain_in;
                  else if ((byte_pos_ff >= pcxd_pkg::BOUNDS_FIRST) &&
                           (byte_pos_ff <= pcxd_pkg::BOUNDS_LAST)) begin
                     // little-endian words, low byte at the even offset
                     if (bound_off[0]) bounds_ff[bound_off[2:1]][15:8] <= plain_in;
                     else              bounds_ff[bound_off[2:1]][7:0]  <= plain_in;
                  end
                  state_ff <= S_DIM;
               end
            end

            S_DIM: begin
               if (pos_ff >= pcxd_pkg::HEADER_END) begin
                  width_ff  <= pcxd_pkg::dim_calc(bounds_ff[0], bounds_ff[2]);
                  height_ff <= pcxd_pkg::dim_calc(bounds_ff[1], bounds_ff[3]);
               end else begin
                  width_ff  <= 17'd0;
                  height_ff <= 17'd0;
               end
               state_ff <= (pos_ff == pcxd_pkg::HEADER_END) ? S_MUL : S_DECODE;
            end

            S_MUL: begin
               prod_ff  <= 34'(width_ff) * 34'(height_ff);
               state_ff <= S_FMT;
            end

            S_FMT: begin
               target_ff <= '0;
               if ((bpp_ff != pcxd_pkg::REQUIRED_BPP) ||
                   (planes_ff != pcxd_pkg::REQUIRED_PLANES) ||
                   (prod_ff > 34'(MAX_PIXELS))) begin
                  if (err_ff == pcxd_pkg::STATUS_OK) err_ff <= pcxd_pkg::STATUS_FORMAT;
               end else begin
                  target_ff <= PIX_W'(prod_ff);
               end
               state_ff <= S_DECODE;
            end

            S_DECODE: begin
               state_ff <= S_TAIL;
               if ((pos_ff >= pcxd_pkg::DATA_FIRST) && (err_ff == pcxd_pkg::STATUS_OK)) begin
                  if (pending_ff[6]) begin
                     pending_ff <= 7'd0;
                     if (pending_ff[5:0] != 6'd0) begin
                        run_cnt_ff <= pending_ff[5:0];
                        state_ff   <= S_RUN;
                     end
                  end else if (pix_cnt_ff < target_ff) begin
                     if (data_ff >= pcxd_pkg::RUN_MARK) begin
                        if (run_overrun) err_ff <= pcxd_pkg::STATUS_RUN_OVERRUN;
                        else             pending_ff <= {1'b1, data_ff[5:0]};
                     end else begin
                        // a literal is a run of one
                        run_cnt_ff <= 6'd1;
                        state_ff   <= S_RUN;
                     end
                  end
               end
            end

            S_RUN: begin
               if (slot_free) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_kind_ff      <= pcxd_pkg::KIND_PIXEL;
                  rsp_value_ff     <= data_ff;
                  rsp_index_ff     <= 24'(pix_cnt_ff);
                  rsp_width_ff     <= width_ff;
                  rsp_height_ff    <= height_ff;
                  rsp_last_ff      <= (run_cnt_ff == 6'd1) && !pal_emit_ff;
                  rsp_file_done_ff <= (run_cnt_ff == 6'd1) && !pal_emit_ff && final_ff;
                  rsp_status_ff    <= ((run_cnt_ff == 6'd1) && !pal_emit_ff && final_ff)
                                      ? status_after_pixel : err_ff;
                  emitted_ff       <= 1'b1;
                  pix_cnt_ff       <= pix_cnt_in;
                  run_cnt_ff       <= run_cnt_ff - 6'd1;
                  if (run_cnt_ff == 6'd1) state_ff <= S_TAIL;
               end
            end

            S_TAIL: begin
               if (pal_emit_ff || (final_ff && !emitted_ff)) begin
                  if (slot_free) begin
                     rsp_valid_ff     <= 1'b1;
                     rsp_kind_ff      <= pal_emit_ff ? pcxd_pkg::KIND_PALETTE
                                                     : pcxd_pkg::KIND_STATUS;
                     rsp_value_ff     <= pal_emit_ff ? data_ff : 8'd0;
                     rsp_index_ff     <= pal_emit_ff ? pal_idx_ff : 24'd0;
                     rsp_width_ff     <= width_ff;
                     rsp_height_ff    <= height_ff;
                     rsp_last_ff      <= 1'b1;
                     rsp_file_done_ff <= final_ff;
                     rsp_status_ff    <= final_ff ? status_at_tail : err_ff;
                     state_ff         <= S_IDLE;
                  end
               end else begin
                  state_ff <= S_IDLE;
               end
               // re-arm for the next file once the closing result is out
               if (final_ff && (slot_free || !(pal_emit_ff || !emitted_ff))) begin
                  byte_pos_ff <= 24'd0;
                  checksum_ff <= seed_ff;
                  for (int i = 0; i < 4; i++) bounds_ff[i] <= 16'd0;
                  bpp_ff      <= 8'd0;
                  planes_ff   <= 8'd0;
                  target_ff   <= '0;
                  pix_cnt_ff  <= '0;
                  pending_ff  <= 7'd0;
                  err_ff      <= pcxd_pkg::STATUS_OK;
               end
            end

            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_value        = rsp_value_ff;
   assign rsp_index        = rsp_index_ff;
   assign rsp_image_width  = rsp_width_ff;
   assign rsp_image_height = rsp_height_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_file_done    = rsp_file_done_ff;
   assign rsp_last         = rsp_last_ff;

endmodule
